// ----- src/utf8d_pkg.sv -----
`timescale 1ns / 1ps
package utf8d_pkg;

  localparam int CpW = 21;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_END   = 2'd1,
    ST_CONT  = 2'd2,
    ST_START = 2'd3
  } status_t;

  localparam logic [7:0] ASCII_MAX  = 8'h7F;
  localparam logic [7:0] LEAD2_MAX  = 8'hDF;
  localparam logic [7:0] LEAD3_MAX  = 8'hEF;
  localparam logic [7:0] LEAD4_MAX  = 8'hF7;
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_TAG   = 8'h80;
  localparam logic [7:0] LEAD2_BITS = 8'h1F;
  localparam logic [7:0] CONT_BITS  = 8'h3F;
  localparam logic [7:0] LEAD3_BITS = 8'h0F;
  localparam logic [7:0] LEAD4_BITS = 8'h07;

  // sequence state carried from byte to byte
  typedef struct packed {
    logic [1:0]     remaining;
    logic [CpW-1:0] acc;
    logic           bad_cont;
    logic           discarding;
  } seq_state_t;

  typedef struct packed {
    logic [CpW-1:0] code_point;
    status_t        status;
    logic           string_done;
  } result_t;

endpackage

// ----- src/utf8_code_point_decoder_unit.sv -----
`timescale 1ns / 1ps
// path: a byte accepted into the input register is decoded and its result
//   (if any) is loaded into the result register; throughput: one byte per cycle
//   while out_ready does not stall the result register (decode is combinational)
// reset: synchronous active-low rst_n empties both stages, clears the sequence
//   state and sets utf16_target to 0
module utf8_code_point_decoder_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic                      cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                in_data_byte,
  input  logic                      in_last_byte,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [utf8d_pkg::CpW-1:0] out_code_point,
  output utf8d_pkg::status_t        out_status,
  output logic                      out_string_done
);
  import utf8d_pkg::*;

  logic       utf16_r;
  logic       s1_vld_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  seq_state_t st_r;
  seq_state_t st_nxt;
  logic       out_vld_r;
  result_t    res_r;
  result_t    res_nxt;
  logic       emit;
  logic       advance;

  assign advance  = s1_vld_r & (~out_vld_r | out_ready);
  assign in_ready = ~s1_vld_r | advance;

  utf8d_step u_step (
    .cur_state    (st_r),
    .data_byte    (s1_byte_r),
    .last_byte    (s1_last_r),
    .utf16_target (utf16_r),
    .nxt_state    (st_nxt),
    .emit         (emit),
    .result       (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      utf16_r   <= 1'b0;
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      st_r      <= '0;
    end else begin
      if (cfg_we) begin
        utf16_r <= cfg_wdata;
      end
      if (in_ready) begin
        s1_vld_r <= in_valid;
      end
      if (advance) begin
        st_r <= st_nxt;
      end
      // result register: load on a producing byte, drop once taken
      if (advance) begin
        out_vld_r <= emit;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
    if (advance && emit) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_code_point  = res_r.code_point;
  assign out_status      = res_r.status;
  assign out_string_done = res_r.string_done;

endmodule

// ----- src/utf8d_step.sv -----
`timescale 1ns / 1ps
module utf8d_step (
  input  utf8d_pkg::seq_state_t cur_state,
  input  logic [7:0]            data_byte,
  input  logic                  last_byte,
  input  logic                  utf16_target,
  output utf8d_pkg::seq_state_t nxt_state,
  output logic                  emit,
  output utf8d_pkg::result_t    result
);
  import utf8d_pkg::*;

  logic           err;
  status_t        err_status;
  logic           bad_now;
  logic [CpW-1:0] acc_shift;
  logic [1:0]     rem_dec;

  assign bad_now   = cur_state.bad_cont | ((data_byte & CONT_MASK) != CONT_TAG);
  assign acc_shift = {cur_state.acc[CpW-7:0], data_byte[5:0] & CONT_BITS[5:0]};
  assign rem_dec   = cur_state.remaining - 2'd1;

  always_comb begin
    nxt_state          = cur_state;
    emit               = 1'b0;
    err                = 1'b0;
    err_status         = ST_OK;
    result.code_point  = '0;
    result.status      = ST_OK;
    result.string_done = last_byte;

    if (cur_state.discarding) begin
      if (last_byte) begin
        nxt_state = '0;
      end
    end else if (cur_state.remaining == 2'd0) begin
      nxt_state.bad_cont = 1'b0;
      unique case (data_byte) inside
        [8'h00:ASCII_MAX]: begin
          emit              = 1'b1;
          result.code_point = CpW'(data_byte);
        end
        [CONT_TAG:8'hBF]: begin
          err        = 1'b1;
          err_status = ST_START;
        end
        [8'hC0:LEAD2_MAX]: begin
          nxt_state.acc       = CpW'(data_byte & LEAD2_BITS);
          nxt_state.remaining = 2'd1;
        end
        [8'hE0:LEAD3_MAX]: begin
          nxt_state.acc       = CpW'(data_byte & LEAD3_BITS);
          nxt_state.remaining = 2'd2;
        end
        [8'hF0:LEAD4_MAX]: begin
          if (utf16_target) begin
            err        = 1'b1;
            err_status = ST_START;
          end else begin
            nxt_state.acc       = CpW'(data_byte & LEAD4_BITS);
            nxt_state.remaining = 2'd3;
          end
        end
        default: begin
          err        = 1'b1;
          err_status = ST_START;
        end
      endcase
      // multi-byte lead on the last byte of the string
      if (!emit && !err && last_byte) begin
        err        = 1'b1;
        err_status = ST_END;
      end
    end else begin
      nxt_state.bad_cont  = bad_now;
      nxt_state.acc       = acc_shift;
      nxt_state.remaining = rem_dec;
      if (rem_dec == 2'd0) begin
        if (bad_now) begin
          err        = 1'b1;
          err_status = ST_CONT;
        end else begin
          emit              = 1'b1;
          result.code_point = acc_shift;
          nxt_state         = '0;
        end
      end else if (last_byte) begin
        err        = 1'b1;
        err_status = ST_END;
      end
    end

    if (err) begin
      emit                 = 1'b1;
      result.code_point    = '0;
      result.status        = err_status;
      result.string_done   = 1'b1;
      nxt_state            = '0;
      nxt_state.discarding = ~last_byte;
    end
  end

endmodule

// ----- src/utf8d_checker.sv -----
`timescale 1ns / 1ps
module utf8d_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [utf8d_pkg::CpW-1:0] out_code_point,
  input utf8d_pkg::status_t        out_status,
  input logic                      out_string_done
);
  import utf8d_pkg::*;

  // errors always close the string
  a_err_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_string_done)
    else $error("error item without string_done");

  // errors carry a zero code point
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_code_point == '0)
    else $error("error item with nonzero code point");

  // nothing comes out and the input is open the cycle after reset
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("result valid or input blocked right after reset");

  // a presented result is fully known
  a_out_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown({out_code_point, out_status, out_string_done}))
    else $error("result item has unknown bits");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_code_point)
      && $stable(out_status) && $stable(out_string_done))
    else $error("stalled result changed");

endmodule

bind utf8_code_point_decoder_unit utf8d_checker u_utf8d_checker (.*);
